/* src/slat_pkg.sv */
`default_nettype none

package slat_pkg;

   localparam int LINE_DEPTH_DEF    = 32;
   localparam int DISPLAY_WIDTH_DEF = 10;

   localparam logic [7:0]  CH_CR         = 8'h0D;
   localparam logic [7:0]  CH_LF         = 8'h0A;
   localparam logic [7:0]  CH_SPACE      = 8'h20;
   localparam logic [15:0] TIMEOUT_RESET = 16'd25;

   localparam logic MODE_BYTE    = 1'b0;
   localparam logic MODE_TICK    = 1'b1;
   localparam logic KIND_ECHO    = 1'b0;
   localparam logic KIND_DISPLAY = 1'b1;

   localparam int         CSR_ADDR_W       = 3;
   localparam logic [2:0] REG_IDLE_TIMEOUT = 3'd0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ECHO,
      ST_READ,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic take;
      logic start_flush;
      logic emit_next;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic is_byte;
      logic timeout_hit;
      logic echo_last;
      logic last_char;
   } sts_type;

endpackage

`default_nettype wire

/* src/serial_line_assembler_timeout.sv */
// echo: result beat offered the cycle after the input beat is accepted
// line flush: echo beat (if any), store read, DISPLAY_WIDTH beats one per cycle unless stalled
// one item at a time: the next item is taken only once the previous one is finished
// a tick that hits the idle timeout: store read, then the DISPLAY_WIDTH display beats, no echo
// flush rate set by the single read port of the line store
// synchronous reset clears line fill, idle counter, typing flag; idle timeout resets to 25
`default_nettype none

module serial_line_assembler_timeout #(
   parameter int LINE_DEPTH    = slat_pkg::LINE_DEPTH_DEF,
   parameter int DISPLAY_WIDTH = slat_pkg::DISPLAY_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,  // rx_byte
   input  wire logic                            req_tuser,  // mode
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [7:0]                           rsp_tdata,  // char_out
   output logic                                 rsp_tuser,  // kind
   output logic                                 rsp_tlast,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [slat_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import slat_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic [15:0] timeout_ff;
   logic [15:0] timeout_in;
   logic        reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr == REG_IDLE_TIMEOUT;

   always_comb begin
      timeout_in = timeout_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && reg_sel) begin
         timeout_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   assign csr_prdata = reg_sel ? {16'd0, timeout_ff} : 32'd0;

   slat_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   slat_dp #(
      .LINE_DEPTH    (LINE_DEPTH),
      .DISPLAY_WIDTH (DISPLAY_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_tuser    (req_tuser),
      .req_tdata    (req_tdata),
      .idle_timeout (timeout_ff),
      .rsp_tuser    (rsp_tuser),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

`default_nettype wire

/* src/slat_ctl.sv */
`default_nettype none

module slat_ctl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output slat_pkg::cmd_type     cmd,
   input  wire slat_pkg::sts_type sts
);
   import slat_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (sts.is_byte) begin
                  state_in = ST_ECHO;
               end else if (sts.timeout_hit) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_ECHO: begin
            if (rsp_tready) begin
               state_in = sts.echo_last ? ST_IDLE : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_tready && sts.last_char) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready      = 1'b0;
      rsp_tvalid      = 1'b0;
      cmd             = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
         end
         ST_ECHO: begin
            rsp_tvalid = 1'b1;
         end
         ST_READ: begin
            cmd.start_flush = 1'b1;
         end
         ST_EMIT: begin
            rsp_tvalid    = 1'b1;
            cmd.emit_next = rsp_tready && !sts.last_char;
            cmd.finish    = rsp_tready && sts.last_char;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input and result side active together");

   a_read_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_EMIT))
      else $error("read cycle not followed by emit");

   a_flush_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_tready && sts.last_char) |=>
      (state_ff == ST_IDLE && req_tready))
      else $error("flush did not return to idle");

endmodule

`default_nettype wire

/* src/slat_dp.sv */
`default_nettype none

module slat_dp #(
   parameter int LINE_DEPTH    = slat_pkg::LINE_DEPTH_DEF,
   parameter int DISPLAY_WIDTH = slat_pkg::DISPLAY_WIDTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire slat_pkg::cmd_type cmd,
   output slat_pkg::sts_type      sts,
   input  wire logic              req_tuser,
   input  wire logic [7:0]        req_tdata,
   input  wire logic [15:0]       idle_timeout,
   output logic                   rsp_tuser,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast
);
   import slat_pkg::*;

   localparam int ADDR_W = $clog2(LINE_DEPTH);
   localparam int IDX_W  = (DISPLAY_WIDTH > 1) ? $clog2(DISPLAY_WIDTH) : 1;
   localparam int CMP_W  = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

   logic [7:0]        line_mem [LINE_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] fill_ff,    fill_in;
   logic [15:0]       idle_ff,    idle_in;
   logic              active_ff,  active_in;
   logic [IDX_W-1:0]  idx_ff,     idx_in;
   logic              hit_ff,     hit_in;
   logic              kind_ff,    kind_in;
   logic [7:0]        echo_ff,    echo_in;
   logic              echo_last_ff, echo_last_in;

   logic              is_end;
   logic              room;
   logic [15:0]       idle_inc;
   logic              wr_en;
   logic              rd_en;
   logic [CMP_W-1:0]  idx_wide;
   logic [ADDR_W-1:0] rd_addr;
   logic              char_last;

   assign is_end    = (req_tdata == CH_CR) || (req_tdata == CH_LF);
   assign room      = fill_ff < ADDR_W'(LINE_DEPTH - 1);
   assign idle_inc  = idle_ff + 16'd1;
   assign char_last = idx_ff == IDX_W'(DISPLAY_WIDTH - 1);

   assign sts.is_byte     = req_tuser == MODE_BYTE;
   assign sts.timeout_hit = active_ff && (idle_inc >= idle_timeout);
   assign sts.echo_last   = echo_last_ff;
   assign sts.last_char   = char_last;

   assign wr_en    = cmd.take && (req_tuser == MODE_BYTE) && !is_end && room;
   assign rd_en    = cmd.start_flush || cmd.emit_next;
   assign idx_wide = CMP_W'(idx_in);
   assign rd_addr  = idx_wide[ADDR_W-1:0];

   always_comb begin
      fill_in      = fill_ff;
      idle_in      = idle_ff;
      active_in    = active_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      kind_in      = kind_ff;
      echo_in      = echo_ff;
      echo_last_in = echo_last_ff;
      if (cmd.take) begin
         if (req_tuser == MODE_BYTE) begin
            echo_in      = req_tdata;
            echo_last_in = !is_end;
            kind_in      = KIND_ECHO;
            idle_in      = '0;
            active_in    = 1'b1;
            if (wr_en) begin
               fill_in = fill_ff + ADDR_W'(1);
            end
         end else if (active_ff) begin
            idle_in = idle_inc;
         end
      end
      if (cmd.start_flush) begin
         idx_in  = '0;
         kind_in = KIND_DISPLAY;
      end else if (cmd.emit_next) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (rd_en) begin
         hit_in = idx_wide < CMP_W'(fill_ff);
      end
      if (cmd.finish) begin
         fill_in   = '0;
         idle_in   = '0;
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         idle_ff   <= '0;
         active_ff <= 1'b0;
         kind_ff   <= KIND_ECHO;
      end else begin
         fill_ff   <= fill_in;
         idle_ff   <= idle_in;
         active_ff <= active_in;
         kind_ff   <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      hit_ff       <= hit_in;
      echo_ff      <= echo_in;
      echo_last_ff <= echo_last_in;
   end

   // line store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[fill_ff] <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   assign rsp_tuser = kind_ff;
   assign rsp_tdata = (kind_ff == KIND_ECHO) ? echo_ff : (hit_ff ? rd_data_ff : CH_SPACE);
   assign rsp_tlast = (kind_ff == KIND_ECHO) ? echo_last_ff : char_last;

endmodule

`default_nettype wire

/* verif/tb.sv */
`default_nettype none

module tb;
   import slat_pkg::*;

   localparam int HOLD_CYCLES = 400;
   localparam int QUIET_LIMIT = 3000;
   localparam int PHASE_ITEMS = 75;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } rx_item_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] ch;
      logic       last;
   } line_char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // rx_byte
   logic        req_tuser = 1'b0;    // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;           // char_out
   logic        rsp_tuser;           // kind
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   serial_line_assembler_timeout dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // line model state
   logic [7:0]  line_buf [LINE_DEPTH_DEF];
   int          line_fill = 0;
   logic [15:0] idle_ticks = 16'd0;
   logic        typing = 1'b0;
   logic [15:0] idle_limit = TIMEOUT_RESET;

   rx_item_type   pending_items [$];
   line_char_type expected_chars [$];
   int            items_queued = 0;
   int            items_taken = 0;
   int            mismatches = 0;

   bit req_fired = 1'b0;
   bit rsp_fired = 1'b0;
   int send_gap = 0;
   bit send_calm = 1'b0;
   int recv_stall = 0;
   bit recv_calm = 1'b0;
   bit hold_arm = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;

   function automatic int pick_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_error(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("error: %s", msg);
   endtask

   task automatic flush_line_expect();
      logic [7:0] ch;
      for (int i = 0; i < DISPLAY_WIDTH_DEF; i++) begin
         ch = (i < line_fill) ? line_buf[i] : CH_SPACE;
         expected_chars.push_back('{KIND_DISPLAY, ch, (i == DISPLAY_WIDTH_DEF - 1)});
      end
      line_fill = 0;
      typing = 1'b0;
      idle_ticks = 16'd0;
   endtask

   task automatic predict_line_chars(input logic mode, input logic [7:0] b);
      logic is_end;
      is_end = (b == CH_CR) || (b == CH_LF);
      if (mode == MODE_BYTE) begin
         expected_chars.push_back('{KIND_ECHO, b, !is_end});
         idle_ticks = 16'd0;
         typing = 1'b1;
         if (is_end) begin
            flush_line_expect();
         end else if (line_fill < LINE_DEPTH_DEF - 1) begin
            line_buf[line_fill] = b;
            line_fill++;
         end
      end else if (typing) begin
         idle_ticks = idle_ticks + 16'd1;
         if (idle_ticks >= idle_limit) flush_line_expect();
      end
   endtask

   // input side: beats accepted and predicted at the rising edge
   always @(posedge clock) begin
      req_fired = !reset && req_tvalid && req_tready;
      if (req_fired) begin
         predict_line_chars(req_tuser, req_tdata);
         items_taken++;
      end
   end

   always @(negedge clock) begin
      rx_item_type it;
      logic        v;
      logic [7:0]  d;
      logic        m;
      v = req_tvalid;
      d = req_tdata;
      m = req_tuser;
      if (reset) begin
         v = 1'b0;
      end else if (!req_tvalid || req_fired) begin
         v = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_items.size() > 0) begin
            it = pending_items.pop_front();
            v = 1'b1;
            d = it.rx_byte;
            m = it.mode;
            if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
            send_gap = pick_gap(send_calm);
         end
      end
      req_tvalid <= v;
      req_tdata  <= d;
      req_tuser  <= m;
   end

   // result side
   always @(posedge clock) begin
      line_char_type exp_c;
      rsp_fired = !reset && rsp_tvalid && rsp_tready;
      if (rsp_fired) begin
         if (expected_chars.size() == 0) begin
            report_error($sformatf("unexpected beat kind=%0d char=%02h last=%0d",
                                   rsp_tuser, rsp_tdata, rsp_tlast));
         end else begin
            exp_c = expected_chars.pop_front();
            if (rsp_tuser !== exp_c.kind || rsp_tdata !== exp_c.ch ||
                rsp_tlast !== exp_c.last)
               report_error($sformatf({"expected kind=%0d char=%02h last=%0d, ",
                                       "got kind=%0d char=%02h last=%0d"},
                                      exp_c.kind, exp_c.ch, exp_c.last,
                                      rsp_tuser, rsp_tdata, rsp_tlast));
         end
      end
   end

   always @(negedge clock) begin
      logic rdy;
      rdy = 1'b0;
      if (reset) begin
         rdy = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
      end else if (hold_arm && !hold_done) begin
         // long back-pressure so the block stalls its input
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end else if (recv_stall > 0) begin
         recv_stall--;
      end else begin
         rdy = 1'b1;
         if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
         recv_stall = pick_gap(recv_calm);
      end
      rsp_tready <= rdy;
   end

   always @(posedge clock) begin
      if (reset || req_fired || rsp_fired || csr_psel) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic queue_item(input logic mode, input logic [7:0] b);
      pending_items.push_back('{mode, b});
      items_queued++;
   endtask

   task automatic wait_drained();
      while (items_taken != items_queued || expected_chars.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      idle_limit = val[15:0];
      // read back
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[15:0] !== val[15:0])
         report_error($sformatf("timeout register read %04h, expected %04h",
                                csr_prdata[15:0], val[15:0]));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic queue_random_lines(input int n_items);
      int start;
      int len;
      int n;
      int r;
      start = items_queued;
      while (items_queued - start < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            queue_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end else begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40)
                                              : $urandom_range(0, 12);
            for (int i = 0; i < len; i++) queue_item(MODE_BYTE, 8'($urandom_range(0, 255)));
            r = $urandom_range(0, 99);
            if (r < 35) begin
               queue_item(MODE_BYTE, CH_CR);
            end else if (r < 65) begin
               queue_item(MODE_BYTE, CH_LF);
            end else begin
               n = (idle_limit <= 16'd16) ? int'(idle_limit) : int'($urandom_range(1, 6));
               // sometimes stop one short so the line keeps growing
               if (n > 1 && $urandom_range(0, 3) == 0) n--;
               if (n < 1) n = 1;
               if ($urandom_range(0, 4) == 0) n += $urandom_range(1, 3);
               for (int i = 0; i < n; i++) queue_item(MODE_TICK, 8'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset timeout
      queue_item(MODE_TICK, 8'hA5);
      queue_item(MODE_BYTE, 8'h00);
      queue_item(MODE_BYTE, 8'hFF);
      queue_item(MODE_BYTE, 8'h41);
      queue_item(MODE_TICK, 8'h00);
      queue_item(MODE_BYTE, CH_CR);
      queue_item(MODE_BYTE, CH_LF);
      queue_item(MODE_TICK, 8'h5A);
      wait_drained();

      // zero timeout flushes on the first tick
      csr_write(REG_IDLE_TIMEOUT, 32'h0);
      queue_item(MODE_BYTE, 8'h55);
      queue_item(MODE_TICK, 8'hFF);
      queue_item(MODE_TICK, 8'h00);
      wait_drained();

      csr_write(REG_IDLE_TIMEOUT, 32'h1);
      queue_item(MODE_BYTE, 8'h68);
      queue_item(MODE_BYTE, 8'h69);
      queue_item(MODE_TICK, 8'h33);
      queue_item(MODE_BYTE, CH_CR);
      wait_drained();

      csr_write(REG_IDLE_TIMEOUT, 32'h3);
      queue_item(MODE_BYTE, 8'h0B);
      queue_item(MODE_TICK, 8'h01);
      queue_item(MODE_TICK, 8'h02);
      queue_item(MODE_BYTE, 8'h0C);
      queue_item(MODE_TICK, 8'h03);
      queue_item(MODE_TICK, 8'h04);
      queue_item(MODE_TICK, 8'h05);
      wait_drained();

      hold_arm = 1'b1;
      csr_write(REG_IDLE_TIMEOUT, 32'h2);
      queue_random_lines(PHASE_ITEMS);
      wait_drained();

      csr_write(REG_IDLE_TIMEOUT, 32'hFFFF_FFFF);
      queue_random_lines(PHASE_ITEMS);
      wait_drained();

      csr_write(REG_IDLE_TIMEOUT, 32'h1);
      queue_random_lines(PHASE_ITEMS);
      wait_drained();

      csr_write(REG_IDLE_TIMEOUT, {16'($urandom_range(0, 65535)), 16'd4});
      queue_random_lines(PHASE_ITEMS);
      wait_drained();

      csr_write(REG_IDLE_TIMEOUT, {16'h0000, 16'($urandom_range(5, 12))});
      queue_random_lines(PHASE_ITEMS);
      wait_drained();

      csr_write(REG_IDLE_TIMEOUT, {16'($urandom_range(0, 65535)), 16'd7});
      queue_random_lines(PHASE_ITEMS);
      wait_drained();

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* serial_line_assembler_timeout.f */
src/slat_pkg.sv
src/slat_ctl.sv
src/slat_dp.sv
src/serial_line_assembler_timeout.sv
verif/tb.sv
